/* rtl/core/fes_pkg.sv */
package fes_pkg;

	localparam int unsigned WIDTH_REG_W = 11;
	localparam int unsigned DEC_W       = 10;
	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned SUM_W       = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_WIDTH = 2'd0,
		REG_RED_DEC      = 2'd1,
		REG_GREEN_DEC    = 2'd2,
		REG_BLUE_DEC     = 2'd3
	} cfg_reg_t;

	localparam logic [WIDTH_REG_W-1:0] REGION_WIDTH_RST = 11'd320;
	localparam logic [DEC_W-1:0]       RED_DEC_RST      = 10'd0;
	localparam logic [DEC_W-1:0]       GREEN_DEC_RST    = 10'd5;
	localparam logic [DEC_W-1:0]       BLUE_DEC_RST     = 10'd100;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic       frame_start;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       row_end;
	} pixel_out_t;

	typedef struct packed {
		logic has_left;
		logic has_right;
		logic row_end;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		logic [DEC_W-1:0] red;
		logic [DEC_W-1:0] green;
		logic [DEC_W-1:0] blue;
	} dec_set_t;

endpackage

/* rtl/core/fes_cfg_regs.sv */
module fes_cfg_regs
	import fes_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output logic [WIDTH_REG_W-1:0] region_width,
	output dec_set_t               decs
);

	logic [WIDTH_REG_W-1:0] region_width_q;
	dec_set_t               decs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_width_q <= REGION_WIDTH_RST;
			decs_q.red     <= RED_DEC_RST;
			decs_q.green   <= GREEN_DEC_RST;
			decs_q.blue    <= BLUE_DEC_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_REGION_WIDTH: region_width_q <= cfg_wdata;
				REG_RED_DEC:      decs_q.red     <= cfg_wdata[DEC_W-1:0];
				REG_GREEN_DEC:    decs_q.green   <= cfg_wdata[DEC_W-1:0];
				REG_BLUE_DEC:     decs_q.blue    <= cfg_wdata[DEC_W-1:0];
				default:          ;
			endcase
		end
	end

	assign region_width = region_width_q;
	assign decs         = decs_q;

endmodule

/* rtl/core/fes_line_buffer.sv */
module fes_line_buffer
	import fes_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned AW        = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  rgb_t          wr_data,
	output rgb_t          rd_data_a,
	output rgb_t          rd_data_b
);

	rgb_t mem [MAX_WIDTH];
	rgb_t rd_data_a_q;
	rgb_t rd_data_b_q;

	// Reads return the contents from before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a_q <= mem[rd_addr_a];
			rd_data_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

/* rtl/core/fes_blend.sv */
module fes_blend
	import fes_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  ctrl_t      ctrl,
	input  rgb_t       cur,
	input  rgb_t       centre,
	input  rgb_t       right,
	input  dec_set_t   decs,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output pixel_out_t out_data
);

	logic       valid_s1;
	ctrl_t      ctrl_s1;
	rgb_t       cur_s1;
	rgb_t       left_q;
	logic       out_valid_q;
	pixel_out_t out_data_q;
	logic       advance;
	pixel_out_t result;

	function automatic logic [7:0] finish(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] l, input logic [7:0] r, input logic use_l, input logic use_r,
		input logic [DEC_W-1:0] dec);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] diff;
		sum = SUM_W'(a) + SUM_W'(b) + (use_l ? SUM_W'(l) : '0) + (use_r ? SUM_W'(r) : '0);
		diff = (sum > dec) ? sum - dec : '0;
		return diff[SUM_W-1:2];
	endfunction

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		result.out_red   = finish(cur_s1.red, centre.red, left_q.red, right.red,
			ctrl_s1.has_left, ctrl_s1.has_right, decs.red);
		result.out_green = finish(cur_s1.green, centre.green, left_q.green, right.green,
			ctrl_s1.has_left, ctrl_s1.has_right, decs.green);
		result.out_blue  = finish(cur_s1.blue, centre.blue, left_q.blue, right.blue,
			ctrl_s1.has_left, ctrl_s1.has_right, decs.blue);
		result.row_end   = ctrl_s1.row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && ctrl_s1.emit;
			end
			// The centre of one pixel is the upper-left neighbour of the next.
			if (valid_s1 && advance) begin
				left_q <= centre;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= ctrl;
			cur_s1  <= cur;
		end
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/core/fire_effect_stencil.sv */
// Fire effect stencil: four-neighbour average over a raster pixel stream.
// Input transactions carry one RGB888 pixel with a frame_start flag on the
// first pixel of a frame; output transactions carry the new value of the pixel
// two rows above the input, with row_end on the last pixel of each row. The
// first two rows of a frame produce no output transactions.
// One pixel is accepted per clock while the receiver takes the output. The
// line buffer is read at the current and the next column (the current one at
// a row's end) and written at the current column in the cycle of acceptance,
// so no interlock is needed. A result passes the blend stage, then the output register.
// The output register and the blend stage form a two-entry pipeline: while
// the receiver stalls, one more pixel can be accepted, after which in_ready
// falls until the output transaction completes.
// Reset clears the column and row counts and loads the register defaults
// (width 320, decrements 0, 5 and 100); the line buffer is not cleared and
// holds defined data once the first row of a frame has passed.
// Configuration is written through cfg_write, cfg_index and cfg_wdata; the user
// must do so only while the block is idle, which the block does not enforce.
module fire_effect_stencil
	import fes_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pixel_in_t             in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pixel_out_t            out_data
);

	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned LW = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;

	logic [WIDTH_REG_W-1:0] region_width;
	dec_set_t               decs;
	logic [AW-1:0]          col_q;
	logic [1:0]             rows_q;
	logic                   take;
	logic [AW-1:0]          x;
	logic [1:0]             rows_cur;
	logic [LW-1:0]          width_ext;
	logic [LW-1:0]          width_eff;
	logic                   last;
	logic [AW-1:0]          right_addr;
	ctrl_t                  ctrl;
	rgb_t                   cur;
	rgb_t                   centre;
	rgb_t                   right;

	fes_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.region_width (region_width),
		.decs         (decs)
	);

	assign take = in_valid && in_ready;

	always_comb begin
		width_ext = LW'(region_width);
		if (width_ext == '0) begin
			width_eff = LW'(1);
		end else if (width_ext > LW'(MAX_WIDTH)) begin
			width_eff = LW'(MAX_WIDTH);
		end else begin
			width_eff = width_ext;
		end
		x        = in_data.frame_start ? '0 : col_q;
		rows_cur = in_data.frame_start ? 2'd0 : rows_q;
		// A narrowed width makes any column at or past the end the last one.
		last     = LW'(x) >= (width_eff - LW'(1));
		right_addr = last ? x : x + AW'(1);
		cur.red   = in_data.in_red;
		cur.green = in_data.in_green;
		cur.blue  = in_data.in_blue;
		ctrl.has_left  = (x != '0);
		ctrl.has_right = !last;
		ctrl.row_end   = last;
		ctrl.emit      = rows_cur[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			rows_q <= 2'd0;
		end else if (take) begin
			if (last) begin
				col_q  <= '0;
				rows_q <= rows_cur[1] ? rows_cur : rows_cur + 2'd1;
			end else begin
				col_q  <= x + AW'(1);
				rows_q <= rows_cur;
			end
		end
	end

	fes_line_buffer #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_line_buffer (
		.clk       (clk),
		.rd_en     (take),
		.rd_addr_a (x),
		.rd_addr_b (right_addr),
		.wr_en     (take),
		.wr_addr   (x),
		.wr_data   (cur),
		.rd_data_a (centre),
		.rd_data_b (right)
	);

	fes_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.ctrl      (ctrl),
		.cur       (cur),
		.centre    (centre),
		.right     (right),
		.decs      (decs),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
